FILE: design/metl_pkg.sv
// Shared types and constants for the muscle energy torque limiter.
// Holds the transaction structs, the configuration register map and field codes.
// No dependencies.
package metl_pkg;

    // Fixed field widths
    localparam int TORQUE_W       = 17;
    localparam int ENERGY_OUT_W   = 17;
    localparam int DEMAND_W       = 16;
    localparam int TORQUE_SCALE_W = 16;
    localparam int STEP_TIME_W    = 16;
    localparam int DAMAGE_W       = 16;
    localparam int TORQUE_SLOTS   = 4;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_LEFT_HIP   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_RIGHT_HIP  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_LEFT_KNEE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_RIGHT_KNEE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_TIME        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTACT_KILLS    = 3'd5;

    localparam logic [TORQUE_SCALE_W-1:0] TORQUE_SCALE_RESET = 16'hFFFF;
    localparam logic [STEP_TIME_W-1:0]    STEP_TIME_RESET    = 16'd2185;
    localparam logic [DAMAGE_W-1:0]       DAMAGE_MAX         = 16'hFFFF;

    // Item kinds and contact parts
    localparam logic       KIND_ACTIVATION = 1'b0;
    localparam logic       KIND_CONTACT    = 1'b1;
    localparam logic [1:0] PART_LEFT_FOOT  = 2'd0;
    localparam logic [1:0] PART_RIGHT_FOOT = 2'd1;

    typedef struct packed {
        logic                       kind;
        logic [1:0]                 joint;
        logic signed [DEMAND_W-1:0] demand;
        logic [1:0]                 contact_part;
        logic                       contact_begin;
    } item_t;

    typedef struct packed {
        logic signed [TORQUE_W-1:0] torque;
        logic [ENERGY_OUT_W-1:0]    energy_after;
        logic                       alive;
        logic                       left_contact;
        logic                       right_contact;
        logic [DAMAGE_W-1:0]        damage_count;
    } result_t;

    typedef struct packed {
        logic [TORQUE_SLOTS-1:0][TORQUE_SCALE_W-1:0] joint_scale;
        logic [STEP_TIME_W-1:0]                      step_time;
        logic                                        contact_kills;
    } cfg_t;

endpackage

FILE: design/muscle_energy_torque_limiter_core.sv
// Top level of the muscle energy torque limiter: sequencer and fixed-point datapath.
// Depends on metl_pkg, metl_cfg_regs and metl_energy_mem.
//
//   channel   signals                                  direction  handshake
//   item      item_valid, item_stall, item             in         valid & !stall
//   result    result_valid, result_stall, result       out        valid & !stall
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data in        valid & ready
//
// An activation transaction issues the memory read at its accepting edge, then steps
// through energy cap (S_READ), the two multiplies (S_MUL), rounding with the drain
// multiply (S_ROUND) and write-back (S_WB); the result register loads in write-back.
// A contact goes from idle straight to write-back. The sequencer returns to idle after
// each write-back and accepts no new transaction before it is back in idle.
// Reset fills all joints with full energy through per-entry written bits; no sweep.
// A stalled result holds in its register; the sequencer waits in write-back until
// that register is free, and the next transaction is accepted the cycle after.
module muscle_energy_torque_limiter_core #(
    parameter int JOINT_COUNT      = 4,
    parameter int ENERGY_FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  metl_pkg::item_t                  item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output metl_pkg::result_t                result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [metl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [metl_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import metl_pkg::*;

    localparam int EFB  = ENERGY_FRAC_BITS;
    localparam int EW   = EFB + 1;
    localparam int AW   = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam int MAGW = EFB + DEMAND_W;
    localparam int TPW  = EW + TORQUE_SCALE_W;
    localparam int SPW  = 2 * EW;
    localparam int DPW  = EW + STEP_TIME_W;
    localparam int GW   = EFB + STEP_TIME_W + 1;
    localparam int GNW  = EFB - 1;
    localparam int SW   = EW + 3;

    localparam logic [EW-1:0] ONE  = EW'(1) << EFB;
    localparam logic [EW-1:0] HALF = EW'(1) << (EFB - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_WB    = 3'd4;

    cfg_t cfg;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    item_t   item_reg;
    logic    joint_ok_reg;
    result_t result_reg;
    logic    result_valid_reg;
    logic    result_valid_next;

    logic                alive_reg, alive_next;
    logic                left_reg, left_next;
    logic                right_reg, right_next;
    logic [DAMAGE_W-1:0] damage_reg, damage_next;

    logic [EW-1:0]      energy_reg;
    logic [EW-1:0]      m_reg;
    logic               neg_reg;
    logic [TPW-1:0]     tq_prod_reg;
    logic [SPW-1:0]     sq_prod_reg;
    logic [GNW-1:0]     gain_reg;
    logic [15:0]        tq_reg;
    logic [DPW-1:0]     drain_prod_reg;

    logic               joint_ok_in;
    logic               rd_en;
    logic [EW-1:0]      rd_data;
    logic               rd_written;
    logic               wr_en;
    logic               wb_go;
    logic               do_act;

    logic               neg;
    logic [15:0]        mag;
    logic [MAGW-1:0]    mag_wide;
    logic [EW-1:0]      m_raw;
    logic [EW-1:0]      cur_energy;
    logic [EW-1:0]      m_sel;
    logic [GW-1:0]      gain_sum;
    logic [TPW:0]       tq_sum;
    logic [17:0]        tq_round;
    logic [SPW:0]       sq_sum;
    logic [EW-1:0]      sq;
    logic [DPW:0]       drain_sum;
    logic [EW:0]        drain;
    logic signed [SW-1:0] e_val;
    logic [EW-1:0]      e_new;
    logic [TORQUE_W-1:0] tq_ext;

    metl_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    metl_energy_mem #(
        .DEPTH (JOINT_COUNT),
        .WIDTH (EW),
        .AW    (AW)
    ) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (rd_en),
        .rd_addr    (AW'(item.joint)),
        .rd_data    (rd_data),
        .rd_written (rd_written),
        .wr_en      (wr_en),
        .wr_addr    (AW'(item_reg.joint)),
        .wr_data    (e_new)
    );

    // Handshake
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign joint_ok_in = (int'(item.joint) < JOINT_COUNT);
    assign rd_en       = (state_reg == S_IDLE) && item_valid
                         && (item.kind == KIND_ACTIVATION) && joint_ok_in;
    assign wb_go       = (state_reg == S_WB) && (!result_valid_reg || !result_stall);
    assign do_act      = (item_reg.kind == KIND_ACTIVATION) && joint_ok_reg;
    assign wr_en       = wb_go && do_act;

    // Demand magnitude and energy cap; zero when the body is not alive
    always_comb
    begin
        neg        = item_reg.demand[DEMAND_W-1];
        mag        = neg ? 16'(17'h10000 - {1'b0, item_reg.demand})
                         : 16'($unsigned(item_reg.demand));
        mag_wide   = MAGW'(mag) << EFB;
        m_raw      = EW'(mag_wide >> 15);
        cur_energy = rd_written ? rd_data : ONE;
        if (!alive_reg)
        begin
            m_sel = '0;
        end
        else if (m_raw > cur_energy)
        begin
            m_sel = cur_energy;
        end
        else
        begin
            m_sel = m_raw;
        end
    end

    // Recovery per step, rounded half up
    assign gain_sum = (GW'(cfg.step_time) << EFB) + GW'(32'h20000);

    // Torque rounding and square rounding
    always_comb
    begin
        tq_sum   = {1'b0, tq_prod_reg} + (TPW + 1)'(HALF);
        tq_round = tq_sum[EFB+17:EFB];
        sq_sum   = {1'b0, sq_prod_reg} + (SPW + 1)'(HALF);
        sq       = sq_sum[EFB+EW-1:EFB];
    end

    // Energy update with clamp to 0..ONE
    always_comb
    begin
        drain_sum = {1'b0, drain_prod_reg} + (DPW + 1)'(32'h8000);
        drain     = drain_sum[DPW:STEP_TIME_W];
        e_val     = $signed(SW'(energy_reg)) - $signed(SW'(drain))
                    + $signed(SW'(gain_reg));
        if (e_val < 0)
        begin
            e_new = '0;
        end
        else if (e_val > $signed(SW'(ONE)))
        begin
            e_new = ONE;
        end
        else
        begin
            e_new = EW'(e_val);
        end
        tq_ext = {1'b0, tq_reg};
    end

    // Body flags after a contact transaction
    always_comb
    begin
        alive_next  = alive_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        damage_next = damage_reg;
        if (wb_go && (item_reg.kind == KIND_CONTACT))
        begin
            case (item_reg.contact_part)
                PART_LEFT_FOOT:  left_next  = item_reg.contact_begin;
                PART_RIGHT_FOOT: right_next = item_reg.contact_begin;
                default:
                begin
                    if (item_reg.contact_begin)
                    begin
                        if (damage_reg != DAMAGE_MAX)
                        begin
                            damage_next = damage_reg + 1'b1;
                        end
                        if (cfg.contact_kills)
                        begin
                            alive_next = 1'b0;
                        end
                    end
                end
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = rd_en ? S_READ : S_WB;
                end
            end
            S_READ:  state_next = S_MUL;
            S_MUL:   state_next = S_ROUND;
            S_ROUND: state_next = S_WB;
            S_WB:
            begin
                if (wb_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Result register occupancy
    always_comb
    begin
        if (wb_go)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            alive_reg        <= 1'b1;
            left_reg         <= 1'b0;
            right_reg        <= 1'b0;
            damage_reg       <= '0;
            joint_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            alive_reg        <= alive_next;
            left_reg         <= left_next;
            right_reg        <= right_next;
            damage_reg       <= damage_next;
            if ((state_reg == S_IDLE) && item_valid)
            begin
                joint_ok_reg <= joint_ok_in;
            end
        end
    end

    // Datapath stages
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && item_valid)
        begin
            item_reg <= item;
        end
        if (state_reg == S_READ)
        begin
            energy_reg <= cur_energy;
            m_reg      <= m_sel;
            neg_reg    <= neg;
        end
        if (state_reg == S_MUL)
        begin
            tq_prod_reg <= TPW'(m_reg) * TPW'(cfg.joint_scale[item_reg.joint]);
            sq_prod_reg <= SPW'(m_reg) * SPW'(m_reg);
            gain_reg    <= gain_sum[GW-1:18];
        end
        if (state_reg == S_ROUND)
        begin
            tq_reg         <= (|tq_round[17:16]) ? 16'hFFFF : tq_round[15:0];
            drain_prod_reg <= DPW'(sq) * DPW'(cfg.step_time);
        end
        if (wb_go)
        begin
            if (do_act)
            begin
                result_reg.torque       <= neg_reg ? $signed(-tq_ext) : $signed(tq_ext);
                result_reg.energy_after <= ENERGY_OUT_W'(e_new);
            end
            else
            begin
                result_reg.torque       <= '0;
                result_reg.energy_after <= '0;
            end
            result_reg.alive         <= alive_next;
            result_reg.left_contact  <= left_next;
            result_reg.right_contact <= right_next;
            result_reg.damage_count  <= damage_next;
        end
    end

endmodule

FILE: design/metl_cfg_regs.sv
// Configuration register file for the torque limiter.
// Decodes index/data writes into the cfg_t bundle; depends on metl_pkg.
module metl_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [metl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [metl_pkg::CFG_DATA_W-1:0]  cfg_data,
    output metl_pkg::cfg_t                   cfg
);
    import metl_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Always take writes
    assign cfg_ready = 1'b1;
    assign cfg     = cfg_reg;

    // Decode the register index, drop indexes beyond the map
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SCALE_LEFT_HIP:   cfg_next.joint_scale[0] = cfg_data;
                CFG_SCALE_RIGHT_HIP:  cfg_next.joint_scale[1] = cfg_data;
                CFG_SCALE_LEFT_KNEE:  cfg_next.joint_scale[2] = cfg_data;
                CFG_SCALE_RIGHT_KNEE: cfg_next.joint_scale[3] = cfg_data;
                CFG_STEP_TIME:        cfg_next.step_time      = cfg_data;
                CFG_CONTACT_KILLS:    cfg_next.contact_kills  = cfg_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.joint_scale   <= {TORQUE_SLOTS{TORQUE_SCALE_RESET}};
            cfg_reg.step_time     <= STEP_TIME_RESET;
            cfg_reg.contact_kills <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: design/metl_energy_mem.sv
// Joint energy store: one-read one-write synchronous memory with registered read data.
// Per-entry written bits mark entries written since reset, the rest count as reset; depends on metl_pkg.
module metl_energy_mem #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 17,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    output logic             rd_written,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);
    import metl_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] written_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_written_reg;

    assign rd_data    = rd_data_reg;
    assign rd_written = rd_written_reg;

    // Write port and registered read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Track which entries have been written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

endmodule
